### src/rob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reorder buffer package
// Field widths, stream packing and fixed limits shared by the reorder buffer
// modules.
// ----------------------------------------------------------------------------
package rob_pkg;

    // Width of a sequence id, of the length register and of the head pointer.
    localparam int LEN_W = 6;
    // Width of the payload field on the input and output streams.
    localparam int DATA_W = 32;
    // Width of the released slot field on the output stream.
    localparam int SLOT_OUT_W = 5;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_TDATA_W = ((LEN_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + SLOT_OUT_W + 7) / 8) * 8;

    // Length register value after reset.
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

    // Most slots that one transaction may release.
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } back_state_t;

endpackage

### src/rob_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reorder buffer front end
// Accepts input transactions, drops ids outside the active length and queues
// the rest as slot writes in a two-entry command queue.
// ----------------------------------------------------------------------------
module rob_front #(
    parameter int SLOT_W = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rob_pkg::LEN_W-1:0] act_len,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [rob_pkg::LEN_W-1:0] in_id,
    input  logic [rob_pkg::DATA_W-1:0] in_payload,
    output logic                      cmd_valid,
    input  logic                      cmd_ready,
    output logic [SLOT_W-1:0]         cmd_slot,
    output logic [rob_pkg::DATA_W-1:0] cmd_payload
);

    logic [SLOT_W-1:0]          slot_q_reg [2];
    logic [rob_pkg::DATA_W-1:0] data_q_reg [2];
    logic [1:0]                 count_reg;
    logic [1:0]                 count_next;
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic                       id_ok;
    logic                       push;
    logic                       pop;
    logic [rob_pkg::LEN_W-1:0]  id_m1;

    // Classify the incoming id: zero or beyond the active length is dropped.
    assign id_ok = (in_id != '0) && (in_id <= act_len);
    assign id_m1 = in_id - rob_pkg::LEN_W'(1);

    assign in_ready = (count_reg != 2'd2);
    assign push = in_valid && in_ready && id_ok;
    assign pop = cmd_valid && cmd_ready;

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd_slot = slot_q_reg[rd_ptr_reg];
    assign cmd_payload = data_q_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Queue storage holds the zero-based slot and the payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_q_reg[wr_ptr_reg] <= id_m1[SLOT_W-1:0];
            data_q_reg[wr_ptr_reg] <= in_payload;
        end
    end

endmodule

### src/rob_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reorder buffer back end
// Writes queued payloads to the slot memory and releases the filled run from
// the head position to the output register, one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module rob_back #(
    parameter int SLOT_COUNT    = 32,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int SLOT_W        = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rob_pkg::LEN_W-1:0]      act_len,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  logic [SLOT_W-1:0]              cmd_slot,
    input  logic [rob_pkg::DATA_W-1:0]     cmd_payload,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rob_pkg::DATA_W-1:0]     out_payload,
    output logic [rob_pkg::SLOT_OUT_W-1:0] out_slot,
    output logic                           out_last
);

    rob_pkg::back_state_t state_reg;
    rob_pkg::back_state_t state_next;

    logic [PAYLOAD_WIDTH-1:0]           slot_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]              filled_reg;
    logic [SLOT_COUNT-1:0]              filled_next;
    logic [SLOT_COUNT-1:0]              filled_eff;
    logic [rob_pkg::LEN_W-1:0]          head_reg;
    logic [rob_pkg::LEN_W-1:0]          head_next;
    logic [rob_pkg::LEN_W-1:0]          head_inc;
    logic [rob_pkg::CNT_W-1:0]          cnt_reg;
    logic [rob_pkg::CNT_W-1:0]          cnt_next;
    logic [rob_pkg::CNT_W-1:0]          cnt_inc;
    logic [PAYLOAD_WIDTH-1:0]           rd_data_reg;
    logic [PAYLOAD_WIDTH-1:0]           wr_data;
    logic [63:0]                        wr_ext;
    logic [63:0]                        rd_ext;
    logic                               out_valid_reg;
    logic [rob_pkg::DATA_W-1:0]         out_payload_reg;
    logic [rob_pkg::SLOT_OUT_W-1:0]     out_slot_reg;
    logic                               out_last_reg;
    logic                               pop;
    logic                               load;
    logic                               head_rel;
    logic                               next_rel;

    // Payload is trimmed to the stored width and widened back for the output.
    assign wr_ext = 64'(cmd_payload);
    assign wr_data = wr_ext[PAYLOAD_WIDTH-1:0];
    assign rd_ext = 64'(rd_data_reg);

    assign cmd_ready = (state_reg == rob_pkg::ST_IDLE);
    assign pop = cmd_valid && cmd_ready;
    assign load = (state_reg == rob_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    // Filled bits as seen right after the current write.
    always_comb
    begin
        filled_eff = filled_reg;
        if (pop)
        begin
            filled_eff[cmd_slot] = 1'b1;
        end
    end

    // Head slot releasable at the end of a write.
    assign head_rel = (head_reg < act_len) && filled_eff[head_reg[SLOT_W-1:0]];

    // Slot after the one being emitted, for the last flag and the next read.
    assign head_inc = head_reg + rob_pkg::LEN_W'(1);
    assign cnt_inc = cnt_reg + rob_pkg::CNT_W'(1);
    assign next_rel = (head_inc < act_len) && filled_reg[head_inc[SLOT_W-1:0]]
                      && (cnt_inc < rob_pkg::CNT_W'(rob_pkg::MAX_RESULTS));

    // Sequencer: a write, then one release per cycle while the output can take it.
    always_comb
    begin
        state_next = state_reg;
        filled_next = filled_eff;
        head_next = head_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            rob_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    cnt_next = '0;
                    if (head_rel)
                    begin
                        state_next = rob_pkg::ST_EMIT;
                    end
                end
            end
            rob_pkg::ST_EMIT:
            begin
                if (load)
                begin
                    head_next = head_inc;
                    cnt_next = cnt_inc;
                    if (!next_rel)
                    begin
                        state_next = rob_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rob_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rob_pkg::ST_IDLE;
            filled_reg <= '0;
            head_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            filled_reg <= filled_next;
            head_reg <= head_next;
            cnt_reg <= cnt_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot_mem[cmd_slot] <= wr_data;
            if (cmd_slot == head_reg[SLOT_W-1:0])
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= slot_mem[head_reg[SLOT_W-1:0]];
            end
        end
        else if (load)
        begin
            rd_data_reg <= slot_mem[head_inc[SLOT_W-1:0]];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_payload_reg <= rd_ext[rob_pkg::DATA_W-1:0];
            out_slot_reg <= head_reg[rob_pkg::SLOT_OUT_W-1:0];
            out_last_reg <= !next_rel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_payload = out_payload_reg;
    assign out_slot = out_slot_reg;
    assign out_last = out_last_reg;

endmodule

### src/in_order_release_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-order release buffer
// Reorder buffer: stores payloads by sequence id and releases them in order
// from the head position up to the first empty slot or the active length.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields
//  s_axis    in         tdata: sequence_id, payload
//  m_axis    out        tdata: released_payload, released_slot; tlast: run_last
//  cfg       in         data: stream_length
//
//  A stored transaction is written, then releases one slot per cycle while the
//  output accepts, a rate set by the single read port of the slot memory.
//  A two-entry command queue lets input transactions arrive while a run drains.
//  Reset clears the filled bits and the head at once; no clearing pass.
//  A stalled output holds the release sequence in place without loss.
// ----------------------------------------------------------------------------
module in_order_release_buffer #(
    parameter int SLOT_COUNT    = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Bits [5:0] sequence_id, [37:6] payload, rest zero.
    input  logic [rob_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bits [31:0] released_payload, [36:32] released_slot, rest zero.
    output logic [rob_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [rob_pkg::LEN_W-1:0]           cfg_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [rob_pkg::LEN_W-1:0]      len_reg;
    logic [rob_pkg::LEN_W-1:0]      act_len;
    logic                           cmd_valid;
    logic                           cmd_ready;
    logic [SLOT_W-1:0]              cmd_slot;
    logic [rob_pkg::DATA_W-1:0]     cmd_payload;
    logic [rob_pkg::DATA_W-1:0]     out_payload;
    logic [rob_pkg::SLOT_OUT_W-1:0] out_slot;

    // Length register, always ready for a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= rob_pkg::LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            len_reg <= cfg_data;
        end
    end

    // Active length is capped at the slot count.
    assign act_len = (7'(len_reg) > 7'(SLOT_COUNT)) ? rob_pkg::LEN_W'(SLOT_COUNT) : len_reg;

    rob_front #(
        .SLOT_W(SLOT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .act_len    (act_len),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_id      (s_axis_tdata[rob_pkg::LEN_W-1:0]),
        .in_payload (s_axis_tdata[rob_pkg::LEN_W+rob_pkg::DATA_W-1:rob_pkg::LEN_W]),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_slot   (cmd_slot),
        .cmd_payload(cmd_payload)
    );

    rob_back #(
        .SLOT_COUNT   (SLOT_COUNT),
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
        .SLOT_W       (SLOT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .act_len    (act_len),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_slot   (cmd_slot),
        .cmd_payload(cmd_payload),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_payload(out_payload),
        .out_slot   (out_slot),
        .out_last   (m_axis_tlast)
    );

    // Pack the output fields, lowest field first.
    assign m_axis_tdata = rob_pkg::OUT_TDATA_W'({out_slot, out_payload});

endmodule
